@@ sv/sha_pkg.sv @@
// Package: SHA-256 constants, types and round functions shared by the hasher modules.
`default_nettype none
package sha_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_FINISH = 1'b1
  } kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;
  } result_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491; 6'd2:  k = 32'hb5c0fbcf;
      6'd3:  k = 32'he9b5dba5; 6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5; 6'd8:  k = 32'hd807aa98;
      6'd9:  k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] initial_hash(input logic [2:0] i);
    logic [31:0] h;
    unique case (i)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ sv/sha_stream_if.sv @@
// Interfaces: valid/ready channels for input words and digest result words.
`default_nettype none
interface sha_item_if
  import sha_pkg::*;
();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sha_result_if
  import sha_pkg::*;
();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/sha_front.sv @@
// Front end: accepts input words and queues them for the compression engine.
`default_nettype none
module sha_front
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       q_valid,
  input  wire logic  q_ready,
  output item_t      q_item
);
  item_t                slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   fill;
  logic                 push;
  logic                 pop;

  assign in_ready = (fill != (QueuePtrW+1)'(QueueDepth));
  assign q_valid  = (fill != '0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  // Store incoming word, with finish items keeping a clean byte field
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr].kind      <= in_item.kind;
      slots[wr_ptr].data_byte <= (in_item.kind == KIND_FINISH) ? 8'h00 : in_item.data_byte;
    end
  end
endmodule
`default_nettype wire

@@ sv/sha_core.sv @@
// Back end: block buffer, padding sequencer, iterative 64-round compression, digest output.
`default_nettype none
module sha_core
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire item_t q_item,
  output logic       out_valid,
  input  wire logic  out_ready,
  output result_t    out_res
);
  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LEN, S_ROUND, S_ADD, S_EMIT
  } state_t;

  state_t       state;
  logic [31:0]  h [8];
  logic [31:0]  v [8];
  logic [31:0]  w [16];
  logic [63:0]  byte_count;
  logic [63:0]  bit_len;
  logic [5:0]   pos;
  logic [5:0]   round;
  logic         final_blk;
  logic         pad_wrapped;
  logic [2:0]   emit_idx;
  logic [2:0]   len_idx;

  logic [31:0]  wt;
  logic [31:0]  w_new;
  logic [31:0]  t1;
  logic [31:0]  t2;
  logic [31:0]  big0;
  logic [31:0]  big1;
  logic [31:0]  ch;
  logic [31:0]  maj;
  logic [31:0]  s0;
  logic [31:0]  s1;
  logic [3:0]   wsel;
  logic [4:0]   byte_lsb;
  logic [7:0]   len_byte;

  assign q_ready   = (state == S_IDLE);
  assign wsel      = pos[5:2];
  // Big-endian byte lane within the word: byte 0 sits in bits 31:24
  assign byte_lsb  = {~pos[1:0], 3'b000};

  // Round datapath: schedule from a 16-word window
  always_comb begin
    s0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    s1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    wt    = w[0];
    big1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch    = v[6] ^ (v[4] & (v[5] ^ v[6]));
    t1    = v[7] + big1 + ch + round_k(round) + wt;
    big0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    maj   = (v[0] & v[1]) | (v[2] & (v[0] | v[1]));
    t2    = big0 + maj;
    len_byte = 8'(bit_len >> (7'd56 - {len_idx, 3'b000}));
  end

  // Hold state, buffers and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      byte_count  <= '0;
      pos         <= '0;
      out_valid   <= 1'b0;
      final_blk   <= 1'b0;
      pad_wrapped <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= initial_hash(3'(i));
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_item.kind == KIND_BYTE) begin
              w[wsel][byte_lsb +: 8] <= q_item.data_byte;
              byte_count <= byte_count + 64'd1;
              pos        <= pos + 6'd1;
              if (pos == 6'd63) begin
                final_blk <= 1'b0;
                round     <= '0;
                for (int i = 0; i < 8; i++) v[i] <= h[i];
                state     <= S_ROUND;
              end
            end else begin
              bit_len <= {byte_count[60:0], 3'b000};
              w[wsel][byte_lsb +: 8] <= 8'h80;
              pos     <= pos + 6'd1;
              state   <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // Zero-fill; compress early once when the length does not fit
          if (pos == 6'd0 && !pad_wrapped) begin
            pad_wrapped <= 1'b1;
            final_blk   <= 1'b0;
            round       <= '0;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            state       <= S_ROUND;
          end else if (pos == 6'd56) begin
            len_idx <= '0;
            state   <= S_LEN;
          end else begin
            w[wsel][byte_lsb +: 8] <= 8'h00;
            pos <= pos + 6'd1;
          end
        end
        S_LEN: begin
          w[wsel][byte_lsb +: 8] <= len_byte;
          pos     <= pos + 6'd1;
          len_idx <= len_idx + 3'd1;
          if (len_idx == 3'd7) begin
            final_blk <= 1'b1;
            round     <= '0;
            for (int i = 0; i < 8; i++) v[i] <= h[i];
            state     <= S_ROUND;
          end
        end
        S_ROUND: begin
          v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
          v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w[i] <= w[i+1];
          w[15] <= w_new;
          round <= round + 6'd1;
          if (round == 6'd63) state <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          if (final_blk) begin
            emit_idx  <= '0;
            out_valid <= 1'b1;
            state     <= S_EMIT;
          end else begin
            // Resume padding after the early block, else take more bytes
            state <= pad_wrapped ? S_PAD : S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              out_valid   <= 1'b0;
              byte_count  <= '0;
              pos         <= '0;
              pad_wrapped <= 1'b0;
              for (int i = 0; i < 8; i++) h[i] <= initial_hash(3'(i));
              state       <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_res.digest_word = h[emit_idx];
  assign out_res.word_index  = emit_idx;
  assign out_res.last        = (emit_idx == 3'd7);
endmodule
`default_nettype wire

@@ sv/sha256_byte_stream_hasher_top.sv @@
// Top level: SHA-256 byte-stream hasher with queued front end and iterative core.
// Each byte word is taken by the core while it is idle; every 64th byte starts a
// compression in the single shared round unit (one round per cycle), during which the
// core takes no new bytes. A finish word pads byte by byte, runs one or two
// compressions and then presents the eight digest words, first word first. A four-entry
// queue in front lets the source keep sending while the core compresses.
`default_nettype none
module sha256_byte_stream_hasher_top
  import sha_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  sha_item_if.sink     in_ch,
  sha_result_if.source out_ch
);
  logic    q_valid;
  logic    q_ready;
  item_t   q_item;
  item_t   in_item;
  result_t res;

  assign in_item = in_ch.data;

  sha_front u_front (
    .clk, .rst,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_item (in_item),
    .q_valid, .q_ready, .q_item
  );

  sha_core u_core (
    .clk, .rst,
    .q_valid, .q_ready, .q_item,
    .out_valid (out_ch.valid), .out_ready (out_ch.ready), .out_res (res)
  );

  assign out_ch.data = res;
endmodule
`default_nettype wire
